/* design/ppfl_pkg.sv */
// Package for the periodic pair force lookup block.
// Codes, reset values and fixed-point constants; no dependencies.
package ppfl_pkg;

    localparam int DEF_MAX_PARTICLES = 64;
    localparam int DEF_TABLE_DEPTH   = 1024;

    // item kinds carried in tuser
    localparam logic [1:0] OP_LOAD_POS   = 2'd0;
    localparam logic [1:0] OP_LOAD_TABLE = 2'd1;
    localparam logic [1:0] OP_COMPUTE    = 2'd2;
    localparam logic [1:0] OP_RESERVED   = 2'd3;   // ignored

    // configuration register indexes
    localparam logic [1:0] REG_BOX_LENGTH     = 2'd0;
    localparam logic [1:0] REG_TABLE_STEP     = 2'd1;
    localparam logic [1:0] REG_PARTICLE_COUNT = 2'd2;

    localparam logic [30:0] RST_BOX_LENGTH     = 31'd655360;
    localparam logic [30:0] RST_TABLE_STEP     = 31'd160;
    localparam logic [6:0]  RST_PARTICLE_COUNT = 7'd64;

    // cutoff 2.5 in Q16.16 and its square in Q32.32
    localparam logic [33:0] CUTOFF    = 34'd163840;
    localparam logic [36:0] CUTOFF_SQ = 37'd26843545600;

endpackage

/* design/periodic_pair_force_lookup.sv */
// Periodic pair force lookup, top level.
// Depends on ppfl_pkg and ppfl_ram (position store and force table).
//
// Load transactions (tuser = load position / load table) are accepted and
// produce nothing. A compute transaction for particle i produces one result
// per partner j = 0..n-1, tlast on the final one. A row starts by fetching
// p_i from the position store. Each partner is worked out by a small sequencer
// over one shared datapath: one position read, minimum-image difference and
// square per axis, a check, a bit-serial square root, a restoring divide by
// the table step, a table read and capture, then the hand-over of the result,
// which waits out any output stall. Out-of-range partners skip the root,
// divide and table read; the self pair skips everything after the position
// read. The input is not ready while a row is in progress.
// Configuration writes are always accepted and must only be issued while idle.
module periodic_pair_force_lookup #(
    parameter int MAX_PARTICLES = ppfl_pkg::DEF_MAX_PARTICLES,
    parameter int TABLE_DEPTH   = ppfl_pkg::DEF_TABLE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: item_index[9:0], pos_x[41:10], pos_y[73:42], pos_z[105:74],
    //        table_value[137:106], zero fill
    input  logic [143:0] i_s_tdata,
    // tuser: op[1:0]
    input  logic [1:0]   i_s_tuser,
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: partner[5:0], pair_value[37:6], zero fill
    output logic [39:0]  o_m_tdata,
    // tuser: in_range[0]
    output logic [0:0]   o_m_tuser,
    output logic         o_m_tlast,
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_data
);

    localparam int PW = $clog2(MAX_PARTICLES);
    localparam int TW = $clog2(TABLE_DEPTH);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CAPI = 4'd1;   // p_i arrives from the store
    localparam logic [3:0] ST_RDJ  = 4'd2;   // read address p_j
    localparam logic [3:0] ST_GETJ = 4'd3;   // p_j arrives
    localparam logic [3:0] ST_DIFF = 4'd4;   // difference and wrap, one axis
    localparam logic [3:0] ST_SQ   = 4'd5;   // magnitude, square, accumulate
    localparam logic [3:0] ST_CHK  = 4'd6;
    localparam logic [3:0] ST_SQRT = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_TADR = 4'd9;
    localparam logic [3:0] ST_TDAT = 4'd10;
    localparam logic [3:0] ST_EMIT = 4'd11;
    localparam logic [3:0] ST_TGET = 4'd12;  // table data arrives

    // input field split
    logic [1:0]  s_op;
    logic [9:0]  s_idx;
    logic [95:0] s_pos;
    logic [31:0] s_tval;
    assign s_op   = i_s_tuser;
    assign s_idx  = i_s_tdata[9:0];
    assign s_pos  = i_s_tdata[105:10];   // {z, y, x}
    assign s_tval = i_s_tdata[137:106];

    logic [3:0]  r_state;
    logic [30:0] r_box, r_step;
    logic [6:0]  r_count;
    logic [6:0]  r_n;
    logic [PW-1:0] r_i, r_j;
    logic [1:0]  r_axis;
    logic [31:0] r_pi [3];
    logic [31:0] r_pj [3];
    logic signed [33:0] r_d;
    logic [36:0] r_acc;
    logic        r_out;
    logic [35:0] r_rem, r_root, r_bit;
    logic [17:0] r_dvd, r_quo;
    logic [31:0] r_drem;
    logic [4:0]  r_cnt;
    logic [TW-1:0] r_k;

    logic        r_m_valid;
    logic [5:0]  r_partner;
    logic [31:0] r_value;
    logic        r_hit;
    logic        r_last;

    logic s_acc, m_acc;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc = i_s_tvalid && o_s_tready;
    assign m_acc = r_m_valid && i_m_tready;

    // particles in use, saturated at the store depth
    logic [6:0] n_use;
    assign n_use = (r_count > 7'(MAX_PARTICLES)) ? 7'(MAX_PARTICLES) : r_count;

    logic start;
    assign start = s_acc && (s_op == ppfl_pkg::OP_COMPUTE) && (n_use != 7'd0)
                   && (s_idx < {3'd0, n_use});

    // stores
    logic          pos_we, tab_we;
    logic [PW-1:0] pos_raddr;
    logic [95:0]   pos_rdata;
    logic [31:0]   tab_rdata;
    assign pos_we = s_acc && (s_op == ppfl_pkg::OP_LOAD_POS)
                    && (s_idx < 10'(MAX_PARTICLES));
    // one bit wider so a full 1024-entry depth compares correctly
    assign tab_we = s_acc && (s_op == ppfl_pkg::OP_LOAD_TABLE)
                    && ({1'b0, s_idx} < 11'(TABLE_DEPTH));
    assign pos_raddr = (r_state == ST_IDLE) ? s_idx[PW-1:0] : r_j;

    ppfl_ram #(.WIDTH(96), .DEPTH(MAX_PARTICLES)) u_pos (
        .i_clk  (i_clk),
        .i_we   (pos_we),
        .i_waddr(s_idx[PW-1:0]),
        .i_wdata(s_pos),
        .i_raddr(pos_raddr),
        .o_rdata(pos_rdata)
    );

    ppfl_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_tab (
        .i_clk  (i_clk),
        .i_we   (tab_we),
        .i_waddr(s_idx[TW-1:0]),
        .i_wdata(s_tval),
        .i_raddr(r_k),
        .o_rdata(tab_rdata)
    );

    // minimum-image difference for the current axis
    logic signed [33:0] d_raw, d_wrap;
    logic signed [34:0] d_two, len_s;
    assign d_raw = {{2{r_pi[r_axis][31]}}, r_pi[r_axis]}
                 - {{2{r_pj[r_axis][31]}}, r_pj[r_axis]};
    assign d_two = {d_raw, 1'b0};
    assign len_s = {4'd0, r_box};
    always_comb begin
        if (d_two <= -len_s) begin
            d_wrap = d_raw + len_s[33:0];
        end else if (d_two >= len_s) begin
            d_wrap = d_raw - len_s[33:0];
        end else begin
            d_wrap = d_raw;
        end
    end

    logic [33:0] d_mag;
    logic [35:0] sq;
    assign d_mag = r_d[33] ? 34'(-r_d) : 34'(r_d);
    assign sq    = 36'(d_mag[17:0] * d_mag[17:0]);

    // one square root step
    logic [35:0] rt_try;
    assign rt_try = r_root + r_bit;

    // one divide step; a zero step divides as one
    logic [31:0] step_eff, dv_sh;
    assign step_eff = (r_step == 31'd0) ? 32'd1 : {1'b0, r_step};
    assign dv_sh    = {r_drem[30:0], r_dvd[17]};

    logic [PW-1:0] j_next;
    assign j_next = r_j + PW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_box     <= ppfl_pkg::RST_BOX_LENGTH;
            r_step    <= ppfl_pkg::RST_TABLE_STEP;
            r_count   <= ppfl_pkg::RST_PARTICLE_COUNT;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    ppfl_pkg::REG_BOX_LENGTH:     r_box   <= i_cfg_data;
                    ppfl_pkg::REG_TABLE_STEP:     r_step  <= i_cfg_data;
                    ppfl_pkg::REG_PARTICLE_COUNT: r_count <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_i     <= s_idx[PW-1:0];
                        r_j     <= '0;
                        r_n     <= n_use;
                        r_state <= ST_CAPI;
                    end
                end
                ST_CAPI: begin
                    r_pi[0] <= pos_rdata[31:0];
                    r_pi[1] <= pos_rdata[63:32];
                    r_pi[2] <= pos_rdata[95:64];
                    r_state <= ST_RDJ;
                end
                ST_RDJ: r_state <= ST_GETJ;
                ST_GETJ: begin
                    r_pj[0] <= pos_rdata[31:0];
                    r_pj[1] <= pos_rdata[63:32];
                    r_pj[2] <= pos_rdata[95:64];
                    r_axis  <= 2'd0;
                    r_acc   <= '0;
                    r_out   <= 1'b0;
                    if (r_j == r_i) begin
                        // self pair: zero, not in range
                        r_value   <= '0;
                        r_hit     <= 1'b0;
                        r_partner <= 6'(r_j);
                        r_last    <= (7'(r_j) == r_n - 7'd1);
                        r_m_valid <= 1'b1;
                        r_state   <= ST_EMIT;
                    end else begin
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_d     <= d_wrap;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    if (d_mag > ppfl_pkg::CUTOFF) begin
                        r_out <= 1'b1;
                    end else begin
                        r_acc <= r_acc + 37'(sq);
                    end
                    if (r_axis == 2'd2) begin
                        r_state <= ST_CHK;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= ST_DIFF;
                    end
                end
                ST_CHK: begin
                    if (r_out || (r_acc > ppfl_pkg::CUTOFF_SQ)) begin
                        r_value   <= '0;
                        r_hit     <= 1'b0;
                        r_partner <= 6'(r_j);
                        r_last    <= (7'(r_j) == r_n - 7'd1);
                        r_m_valid <= 1'b1;
                        r_state   <= ST_EMIT;
                    end else begin
                        // within cutoff the sum fits 36 bits
                        r_rem   <= r_acc[35:0];
                        r_root  <= '0;
                        r_bit   <= 36'd1 << 34;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_rem >= rt_try) begin
                        r_rem  <= r_rem - rt_try;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= ST_DIV;
                        r_cnt   <= 5'd0;
                        r_drem  <= '0;
                        r_quo   <= '0;
                        // final root value is formed this cycle
                        r_dvd   <= (r_rem >= rt_try) ? 18'((r_root >> 1) + r_bit)
                                                     : 18'(r_root >> 1);
                    end
                end
                ST_DIV: begin
                    if (dv_sh >= step_eff) begin
                        r_drem <= dv_sh - step_eff;
                        r_quo  <= {r_quo[16:0], 1'b1};
                    end else begin
                        r_drem <= dv_sh;
                        r_quo  <= {r_quo[16:0], 1'b0};
                    end
                    r_dvd <= {r_dvd[16:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd17) begin
                        r_state <= ST_TADR;
                    end
                end
                ST_TADR: begin
                    // saturate the index at the last entry
                    r_k     <= (r_quo > 18'(TABLE_DEPTH - 1)) ? TW'(TABLE_DEPTH - 1)
                                                               : r_quo[TW-1:0];
                    r_state <= ST_TDAT;
                end
                ST_TDAT: r_state <= ST_TGET;
                ST_TGET: begin
                    // table data is valid this cycle
                    r_value   <= tab_rdata;
                    r_hit     <= 1'b1;
                    r_partner <= 6'(r_j);
                    r_last    <= (7'(r_j) == r_n - 7'd1);
                    r_m_valid <= 1'b1;
                    r_state   <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (m_acc) begin
                        r_m_valid <= 1'b0;
                        if (r_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_j     <= j_next;
                            r_state <= ST_RDJ;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00, r_value, r_partner};
    assign o_m_tuser  = r_hit;
    assign o_m_tlast  = r_last;

    // a result waiting means the input is closed
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while a result is pending");

    // the final result of a row returns the block to idle
    a_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("block not idle after last result");

    // partner index stays inside the row
    a_partner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (7'(o_m_tdata[5:0]) < r_n))
        else $error("partner beyond particles in use");

endmodule

/* design/ppfl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ppfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
